// ===== design/rfpwd_pkg.sv =====
// Package for the RF remote pulse-width decoder.
// Holds the beat types, frame constants and configuration register indexes.
// No dependencies.
`default_nettype none

package rfpwd_pkg;

    // Frame geometry
    localparam int unsigned FRAME_BITS = 24;
    localparam int unsigned BITS_W     = $clog2(FRAME_BITS + 1);
    localparam int unsigned ADDR_W     = 20;
    localparam int unsigned KEY_W      = 4;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    // Fixed bit windows in ticks
    localparam logic [TICK_W-1:0] ONE_LOW_MIN   = 32'd12;
    localparam logic [TICK_W-1:0] ONE_LOW_MAX   = 32'd30;
    localparam logic [TICK_W-1:0] ZERO_HIGH_MIN = 32'd8;
    localparam logic [TICK_W-1:0] ZERO_HIGH_MAX = 32'd30;

    // Register reset values
    localparam logic [15:0]       SYNC_LOW_MIN_RST = 16'd487;
    localparam logic [15:0]       SYNC_LOW_MAX_RST = 16'd800;
    localparam logic [15:0]       ONE_HIGH_MIN_RST = 16'd43;
    localparam logic [15:0]       ONE_HIGH_MAX_RST = 16'd80;
    localparam logic [15:0]       ZERO_LOW_MIN_RST = 16'd46;
    localparam logic [15:0]       ZERO_LOW_MAX_RST = 16'd80;
    localparam logic [7:0]        GLITCH_LIMIT_RST = 8'd8;
    localparam logic [TICK_W-1:0] REPEAT_GAP_RST   = 32'd15625;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_LOW_MIN = 3'd0,
        CFG_SYNC_LOW_MAX = 3'd1,
        CFG_ONE_HIGH_MIN = 3'd2,
        CFG_ONE_HIGH_MAX = 3'd3,
        CFG_ZERO_LOW_MIN = 3'd4,
        CFG_ZERO_LOW_MAX = 3'd5,
        CFG_GLITCH_LIMIT = 3'd6,
        CFG_REPEAT_GAP   = 3'd7
    } t_cfg_idx;

    // Input beat: one line edge
    typedef struct packed {
        logic              line_level;
        logic [TICK_W-1:0] edge_tick;
    } t_in_item;

    // Output beat: one decoded frame
    typedef struct packed {
        logic [ADDR_W-1:0] address_code;
        logic [KEY_W-1:0]  key_value;
        logic              fresh;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/rf_remote_pulse_width_decoder_top.sv =====
// Top level of the RF remote pulse-width decoder: edge beats in, 24-bit frames out.
// Depends on rfpwd_pkg for beat types, constants and register indexes.
//
// Takes one edge beat per clock cycle unless the input stalls. An accepted edge is
// registered, decoded against the timing state once the frame slot can take a
// result, and a completed frame is then registered on the output register. The edge
// register can still take an edge while a finished frame waits for the consumer;
// the input stalls when both the edge register and the frame register are full
// and the consumer is not ready. Configuration writes take effect on the next cycle
// and must only be issued while no edge is in flight.
`default_nettype none

module rf_remote_pulse_width_decoder_top (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    // configuration write port
    input  wire                                          i_cfg_we,
    input  wire        [rfpwd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire        [rfpwd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // edge input channel
    input  wire                                          i_in_valid,
    output logic                                         o_in_ready,
    input  wire rfpwd_pkg::t_in_item                     i_in_data,
    // frame output channel
    output logic                                         o_out_valid,
    input  wire                                          i_out_ready,
    output rfpwd_pkg::t_out_item                         o_out_data
);

    localparam int unsigned TW = rfpwd_pkg::TICK_W;
    localparam int unsigned FB = rfpwd_pkg::FRAME_BITS;
    localparam int unsigned BW = rfpwd_pkg::BITS_W;

    // configuration registers
    logic [15:0]   r_sync_low_min, r_sync_low_max;
    logic [15:0]   r_one_high_min, r_one_high_max;
    logic [15:0]   r_zero_low_min, r_zero_low_max;
    logic [7:0]    r_glitch_limit;
    logic [TW-1:0] r_repeat_gap;

    // pipeline registers
    logic                 r_in_valid;
    rfpwd_pkg::t_in_item  r_in_data;
    logic                 r_out_valid;
    rfpwd_pkg::t_out_item r_out_data;

    // decoder state
    logic [TW-1:0] r_last_edge, n_last_edge;
    logic [TW-1:0] r_high_time, n_high_time;
    logic          r_receiving, n_receiving;
    logic [BW-1:0] r_bits_left, n_bits_left;
    logic [FB-1:0] r_shift, n_shift;
    logic [TW-1:0] r_last_frame, n_last_frame;

    // decode signals
    logic                 adv;
    logic                 emit;
    logic [TW-1:0]        elapsed;
    logic [TW:0]          period;
    logic                 is_glitch, is_sync, is_one, is_zero;
    logic [BW-1:0]        bits_dec;
    logic [31:0]          frame_word;
    logic [TW-1:0]        frame_gap;
    rfpwd_pkg::t_out_item n_out_data;

    // Move the registered edge into decode when the frame slot can take a result
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_low_min <= rfpwd_pkg::SYNC_LOW_MIN_RST;
            r_sync_low_max <= rfpwd_pkg::SYNC_LOW_MAX_RST;
            r_one_high_min <= rfpwd_pkg::ONE_HIGH_MIN_RST;
            r_one_high_max <= rfpwd_pkg::ONE_HIGH_MAX_RST;
            r_zero_low_min <= rfpwd_pkg::ZERO_LOW_MIN_RST;
            r_zero_low_max <= rfpwd_pkg::ZERO_LOW_MAX_RST;
            r_glitch_limit <= rfpwd_pkg::GLITCH_LIMIT_RST;
            r_repeat_gap   <= rfpwd_pkg::REPEAT_GAP_RST;
        end else if (i_cfg_we) begin
            case (rfpwd_pkg::t_cfg_idx'(i_cfg_index))
                rfpwd_pkg::CFG_SYNC_LOW_MIN: r_sync_low_min <= i_cfg_data[15:0];
                rfpwd_pkg::CFG_SYNC_LOW_MAX: r_sync_low_max <= i_cfg_data[15:0];
                rfpwd_pkg::CFG_ONE_HIGH_MIN: r_one_high_min <= i_cfg_data[15:0];
                rfpwd_pkg::CFG_ONE_HIGH_MAX: r_one_high_max <= i_cfg_data[15:0];
                rfpwd_pkg::CFG_ZERO_LOW_MIN: r_zero_low_min <= i_cfg_data[15:0];
                rfpwd_pkg::CFG_ZERO_LOW_MAX: r_zero_low_max <= i_cfg_data[15:0];
                rfpwd_pkg::CFG_GLITCH_LIMIT: r_glitch_limit <= i_cfg_data[7:0];
                rfpwd_pkg::CFG_REPEAT_GAP:   r_repeat_gap   <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Capture the edge beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Measure and classify the pulse
    always_comb begin
        elapsed   = r_in_data.edge_tick - r_last_edge;
        period    = {1'b0, r_high_time} + {1'b0, elapsed};
        is_glitch = period <= (TW+1)'(r_glitch_limit);
        is_sync   = (elapsed >= TW'(r_sync_low_min)) && (elapsed <= TW'(r_sync_low_max));
        is_one    = r_receiving && (r_high_time > elapsed)
                 && (r_high_time >= TW'(r_one_high_min))
                 && (r_high_time <= TW'(r_one_high_max))
                 && (elapsed >= rfpwd_pkg::ONE_LOW_MIN)
                 && (elapsed <= rfpwd_pkg::ONE_LOW_MAX);
        is_zero   = r_receiving && (r_high_time < elapsed)
                 && (r_high_time >= rfpwd_pkg::ZERO_HIGH_MIN)
                 && (r_high_time <= rfpwd_pkg::ZERO_HIGH_MAX)
                 && (elapsed >= TW'(r_zero_low_min))
                 && (elapsed <= TW'(r_zero_low_max));
        bits_dec  = (r_bits_left != '0) ? r_bits_left - BW'(1) : r_bits_left;
        frame_gap = r_in_data.edge_tick - r_last_frame;
    end

    // Advance the decoder state
    always_comb begin
        n_last_edge  = r_last_edge;
        n_high_time  = r_high_time;
        n_receiving  = r_receiving;
        n_bits_left  = r_bits_left;
        n_shift      = r_shift;
        n_last_frame = r_last_frame;
        emit         = 1'b0;
        if (adv) begin
            n_last_edge = r_in_data.edge_tick;
            if (!r_in_data.line_level) begin
                n_high_time = elapsed;
            end else if (is_glitch) begin
                // drop short pulses
            end else if (is_sync) begin
                n_receiving = 1'b1;
                n_bits_left = BW'(FB);
                n_shift     = '0;
            end else if (is_one || is_zero) begin
                n_shift     = {r_shift[FB-2:0], is_one};
                n_bits_left = bits_dec;
                if (bits_dec == '0) begin
                    emit         = 1'b1;
                    n_last_frame = r_in_data.edge_tick;
                    n_bits_left  = BW'(FB);
                    n_shift      = '0;
                end
            end else begin
                n_receiving = 1'b0;
            end
        end
    end

    // Format the frame
    always_comb begin
        frame_word              = 32'({r_shift[FB-2:0], is_one});
        n_out_data.address_code = frame_word[rfpwd_pkg::ADDR_W+rfpwd_pkg::KEY_W-1:
                                             rfpwd_pkg::KEY_W];
        n_out_data.key_value    = frame_word[rfpwd_pkg::KEY_W-1:0];
        n_out_data.fresh        = frame_gap > r_repeat_gap;
    end

    // Hold decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge  <= '0;
            r_high_time  <= '0;
            r_receiving  <= 1'b0;
            r_bits_left  <= BW'(FB);
            r_shift      <= '0;
            r_last_frame <= '0;
        end else begin
            r_last_edge  <= n_last_edge;
            r_high_time  <= n_high_time;
            r_receiving  <= n_receiving;
            r_bits_left  <= n_bits_left;
            r_shift      <= n_shift;
            r_last_frame <= n_last_frame;
        end
    end

    // Hold the frame beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== design/rfpwd_checker.sv =====
// Port-level checker for the RF remote pulse-width decoder, bound to the top level.
// Depends on rfpwd_pkg for the beat types.
`default_nettype none

module rfpwd_checker (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_in_valid,
    input wire                       o_in_ready,
    input wire                       o_out_valid,
    input wire                       i_out_ready,
    input wire rfpwd_pkg::t_out_item o_out_data
);

    // A frame beat only appears after an edge beat was taken
    a_frame_after_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("frame beat without a preceding edge beat");

    // Input stalls only under output backpressure
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    // Output beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output beat dropped or changed while stalled");

    // No frame beat right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("frame beat present after reset");

endmodule

bind rf_remote_pulse_width_decoder_top rfpwd_checker u_rfpwd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== test/rf_remote_pulse_width_decoder_top_tb.sv =====
// Self-checking testbench for rf_remote_pulse_width_decoder_top: line edges in, frames out.
// Depends on rfpwd_pkg for beat types, register indexes and reset values; needs no files.
`default_nettype none

module rf_remote_pulse_width_decoder_top_tb;
    import rfpwd_pkg::*;

    localparam int unsigned FRAME_LEN    = FRAME_BITS;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned IDLE_PCT     = 28;
    localparam int unsigned PHASE_EDGES  = 300;
    localparam int unsigned PHASE_FRAMES = 4;
    localparam int unsigned MAX_PRINTS   = 40;

    // Fixed bit windows in ticks
    localparam logic [31:0] LOW_OF_ONE_MIN   = 32'd12;
    localparam logic [31:0] LOW_OF_ONE_MAX   = 32'd30;
    localparam logic [31:0] HIGH_OF_ZERO_MIN = 32'd8;
    localparam logic [31:0] HIGH_OF_ZERO_MAX = 32'd30;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;

    rf_remote_pulse_width_decoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Decoder settings as last written
    logic [15:0] cfg_sync_min, cfg_sync_max;
    logic [15:0] cfg_one_high_min, cfg_one_high_max;
    logic [15:0] cfg_zero_low_min, cfg_zero_low_max;
    logic [7:0]  cfg_glitch;
    logic [31:0] cfg_repeat_gap;

    // Line timing and frame assembly state
    logic [31:0]          last_edge_tick;
    logic [31:0]          high_ticks;
    logic                 in_frame;
    logic [BITS_W-1:0]    bits_to_go;
    logic [FRAME_LEN-1:0] frame_word;
    logic [31:0]          last_frame_tick;

    t_out_item   frames_due[$];
    int unsigned mismatches;
    int unsigned frames_seen;
    int unsigned edges_sent;
    int unsigned cycle_count;
    logic [31:0] tick_now;
    logic        in_gaps_on;
    logic        out_stalls_on;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Randomly stall the frame consumer
    always @(negedge i_clk) begin
        i_out_ready <= !out_stalls_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic clear_line_state();
        cfg_sync_min     = SYNC_LOW_MIN_RST;
        cfg_sync_max     = SYNC_LOW_MAX_RST;
        cfg_one_high_min = ONE_HIGH_MIN_RST;
        cfg_one_high_max = ONE_HIGH_MAX_RST;
        cfg_zero_low_min = ZERO_LOW_MIN_RST;
        cfg_zero_low_max = ZERO_LOW_MAX_RST;
        cfg_glitch       = GLITCH_LIMIT_RST;
        cfg_repeat_gap   = REPEAT_GAP_RST;
        last_edge_tick   = '0;
        high_ticks       = '0;
        in_frame         = 1'b0;
        bits_to_go       = BITS_W'(FRAME_LEN);
        frame_word       = '0;
        last_frame_tick  = '0;
    endtask

    // Advance the decoder by one edge; return 1 when it completes a frame
    function automatic bit decode_edge(input t_in_item beat, output t_out_item frame);
        logic [31:0] now;
        logic [31:0] gap_ticks;
        logic [32:0] pulse_sum;
        logic        bit_val;

        frame     = '0;
        now       = beat.edge_tick;
        gap_ticks = now - last_edge_tick;
        last_edge_tick = now;
        if (!beat.line_level) begin
            high_ticks = gap_ticks;
            return 1'b0;
        end

        // Drop short pulses; the sum must not wrap
        pulse_sum = {1'b0, high_ticks} + {1'b0, gap_ticks};
        if (pulse_sum <= {25'd0, cfg_glitch})
            return 1'b0;

        if (gap_ticks >= cfg_sync_min && gap_ticks <= cfg_sync_max) begin
            in_frame   = 1'b1;
            bits_to_go = BITS_W'(FRAME_LEN);
            frame_word = '0;
            return 1'b0;
        end

        if (in_frame && high_ticks > gap_ticks &&
            high_ticks >= cfg_one_high_min && high_ticks <= cfg_one_high_max &&
            gap_ticks >= LOW_OF_ONE_MIN && gap_ticks <= LOW_OF_ONE_MAX) begin
            bit_val = 1'b1;
        end else if (in_frame && high_ticks < gap_ticks &&
                     high_ticks >= HIGH_OF_ZERO_MIN && high_ticks <= HIGH_OF_ZERO_MAX &&
                     gap_ticks >= cfg_zero_low_min && gap_ticks <= cfg_zero_low_max) begin
            bit_val = 1'b0;
        end else begin
            in_frame = 1'b0;
            return 1'b0;
        end

        frame_word = {frame_word[FRAME_LEN-2:0], bit_val};
        if (bits_to_go != 0)
            bits_to_go = bits_to_go - 1'b1;
        if (bits_to_go != 0)
            return 1'b0;

        frame.address_code = frame_word[FRAME_LEN-1 -: ADDR_W];
        frame.key_value    = frame_word[KEY_W-1:0];
        frame.fresh        = (now - last_frame_tick) > cfg_repeat_gap;
        last_frame_tick    = now;
        bits_to_go         = BITS_W'(FRAME_LEN);
        frame_word         = '0;
        return 1'b1;
    endfunction

    // Check each frame beat, then predict from each edge beat
    always @(posedge i_clk) begin
        t_out_item got_frame;
        t_out_item want_frame;
        t_out_item new_frame;

        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_frame = o_out_data;
                frames_seen++;
                if (frames_due.size() == 0) begin
                    report_mismatch("unexpected frame", 32'(got_frame), '0);
                end else begin
                    want_frame = frames_due.pop_front();
                    if (got_frame.address_code !== want_frame.address_code)
                        report_mismatch("address_code", 32'(got_frame.address_code),
                                        32'(want_frame.address_code));
                    if (got_frame.key_value !== want_frame.key_value)
                        report_mismatch("key_value", 32'(got_frame.key_value),
                                        32'(want_frame.key_value));
                    if (got_frame.fresh !== want_frame.fresh)
                        report_mismatch("fresh", 32'(got_frame.fresh),
                                        32'(want_frame.fresh));
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (decode_edge(i_in_data, new_frame))
                    frames_due.push_back(new_frame);
            end
        end
    end

    // Offer one edge beat and hold it until taken; returns just after the taking edge
    task automatic send_edge(input logic level, input logic [31:0] tick);
        @(negedge i_clk);
        while (in_gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= {level, tick};
        tick_now = tick;
        edges_sent++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic park_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Hold the sender until every expected frame is out and the pipe is empty
    task automatic wait_drained();
        park_input();
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SYNC_LOW_MIN: cfg_sync_min     = value[15:0];
            CFG_SYNC_LOW_MAX: cfg_sync_max     = value[15:0];
            CFG_ONE_HIGH_MIN: cfg_one_high_min = value[15:0];
            CFG_ONE_HIGH_MAX: cfg_one_high_max = value[15:0];
            CFG_ZERO_LOW_MIN: cfg_zero_low_min = value[15:0];
            CFG_ZERO_LOW_MAX: cfg_zero_low_max = value[15:0];
            CFG_GLITCH_LIMIT: cfg_glitch       = value[7:0];
            CFG_REPEAT_GAP:   cfg_repeat_gap   = value;
            default: ;
        endcase
    endtask

    task automatic write_windows(input logic [15:0] sync_min, input logic [15:0] sync_max,
                                 input logic [15:0] one_min, input logic [15:0] one_max,
                                 input logic [15:0] zero_min, input logic [15:0] zero_max,
                                 input logic [7:0] glitch, input logic [31:0] gap);
        cfg_write(CFG_SYNC_LOW_MIN, 32'(sync_min));
        cfg_write(CFG_SYNC_LOW_MAX, 32'(sync_max));
        cfg_write(CFG_ONE_HIGH_MIN, 32'(one_min));
        cfg_write(CFG_ONE_HIGH_MAX, 32'(one_max));
        cfg_write(CFG_ZERO_LOW_MIN, 32'(zero_min));
        cfg_write(CFG_ZERO_LOW_MAX, 32'(zero_max));
        cfg_write(CFG_GLITCH_LIMIT, 32'(glitch));
        cfg_write(CFG_REPEAT_GAP, gap);
    endtask

    // Mostly near the low end of a window, sometimes right on an edge of it
    function automatic logic [31:0] pick_in(input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] span;

        if (hi <= lo)
            return lo;
        span = hi - lo;
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return hi;
            default: return lo + $urandom_range(0, (span > 300) ? 300 : span);
        endcase
    endfunction

    // One high/low pulse: falling edge after the high time, rising after the low time
    task automatic send_pulse(input logic [31:0] high_len, input logic [31:0] low_len);
        send_edge(1'b0, tick_now + high_len);
        send_edge(1'b1, tick_now + low_len);
    endtask

    task automatic send_sync_pulse();
        send_pulse(pick_in(8, 600), pick_in(32'(cfg_sync_min), 32'(cfg_sync_max)));
    endtask

    task automatic send_bit(input logic value);
        if (value)
            send_pulse(pick_in((cfg_one_high_min > 31) ? 32'(cfg_one_high_min) : 32'd31,
                               32'(cfg_one_high_max)),
                       pick_in(LOW_OF_ONE_MIN, LOW_OF_ONE_MAX));
        else
            send_pulse(pick_in(HIGH_OF_ZERO_MIN, HIGH_OF_ZERO_MAX),
                       pick_in((cfg_zero_low_min > 31) ? 32'(cfg_zero_low_min) : 32'd31,
                               32'(cfg_zero_low_max)));
    endtask

    // Pulse short enough to be dropped; it must not disturb a frame in progress
    task automatic send_glitch_pulse();
        logic [31:0] high_len;

        high_len = $urandom_range(0, cfg_glitch);
        send_pulse(high_len, $urandom_range(0, 32'(cfg_glitch) - high_len));
    endtask

    // Let line time pass before the next burst, now and then across the wrap
    task automatic advance_line_time();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: tick_now = tick_now + $urandom_range(0, 2000);
            5, 6, 7:       tick_now = tick_now + $urandom_range(0, 60000);
            8:             tick_now = $urandom;
            default:       tick_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        endcase
    endtask

    task automatic send_frame(input logic with_sync);
        logic [FRAME_LEN-1:0] word;
        int                   i;

        word = FRAME_LEN'($urandom);
        if (with_sync) begin
            advance_line_time();
            send_sync_pulse();
        end
        for (i = FRAME_LEN - 1; i >= 0; i--) begin
            if ($urandom_range(0, 9) == 0)
                send_glitch_pulse();
            send_bit(word[i]);
        end
    endtask

    task automatic send_broken_frame();
        int unsigned n_bits;
        int unsigned i;

        advance_line_time();
        send_sync_pulse();
        n_bits = $urandom_range(0, FRAME_LEN - 1);
        for (i = 0; i < n_bits; i++)
            send_bit(1'($urandom_range(0, 1)));
        send_pulse($urandom_range(0, 3000), $urandom_range(0, 3000));
    endtask

    task automatic send_noise();
        int unsigned n_edges;
        int unsigned i;

        n_edges = $urandom_range(1, 6);
        for (i = 0; i < n_edges; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_edge(1'($urandom_range(0, 1)), $urandom);
            else
                send_edge(1'($urandom_range(0, 1)), tick_now + $urandom_range(0, 3000));
        end
    endtask

    // Mostly well-formed frames, some back to back; the rest broken frames and noise
    task automatic run_traffic(input int unsigned edge_budget, input int unsigned frame_goal);
        int unsigned edge_base;
        int unsigned frame_base;
        int unsigned choice;

        edge_base  = edges_sent;
        frame_base = frames_seen;
        while (((edges_sent - edge_base) < edge_budget ||
                (frames_seen - frame_base) < frame_goal) &&
               (edges_sent - edge_base) < 4 * edge_budget) begin
            choice = $urandom_range(0, 99);
            if (choice < 45)
                send_frame(1'b1);
            else if (choice < 62)
                send_frame(1'b0);
            else if (choice < 77)
                send_broken_frame();
            else if (choice < 97)
                send_noise();
            else
                wait_drained();
        end
        wait_drained();
    endtask

    // Field extremes, wrap, repeated level, glitch limit, sync window edges
    task automatic test_directed_edges();
        send_edge(1'b1, 32'h0000_0000);
        send_edge(1'b0, 32'hFFFF_FFFF);
        send_edge(1'b1, 32'h0000_0100);
        send_edge(1'b0, 32'h0000_0120);
        send_edge(1'b0, 32'h0000_0150);
        send_edge(1'b1, 32'h0000_03A0);
        send_pulse(60, 20);
        send_pulse(100, 600);
        send_pulse(3, 4);
        send_pulse(4, 5);
        send_pulse(50, 487);
        send_pulse(50, 800);
        send_pulse(80, 30);
        send_pulse(30, 46);
        send_pulse(43, 12);
        send_pulse(8, 80);
        send_pulse(50, 801);
        wait_drained();
    endtask

    task automatic test_reset_windows();
        out_stalls_on = 1'b0;
        in_gaps_on    = 1'b0;
        run_traffic(PHASE_EDGES, PHASE_FRAMES);
        out_stalls_on = 1'b1;
        in_gaps_on    = 1'b1;
    endtask

    task automatic test_low_extremes();
        write_windows(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 8'd0, 32'd0);
        run_traffic(PHASE_EDGES, PHASE_FRAMES);
    endtask

    task automatic test_high_extremes();
        write_windows(16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      8'hFF, 32'hFFFF_FFFF);
        run_traffic(PHASE_EDGES, PHASE_FRAMES);
    endtask

    // Random windows; keep the sync window clear of the bit windows
    task automatic test_random_windows();
        logic [15:0] zero_min, zero_max, sync_min, one_min;
        int          round;

        for (round = 0; round < 2; round++) begin
            zero_min = 16'($urandom_range(31, 150));
            zero_max = 16'(zero_min + $urandom_range(0, 200));
            sync_min = 16'(zero_max + 1 + $urandom_range(0, 1000));
            one_min  = 16'($urandom_range(31, 150));
            write_windows(sync_min, 16'(sync_min + $urandom_range(0, 2000)),
                          one_min, 16'(one_min + $urandom_range(0, 200)),
                          zero_min, zero_max,
                          8'($urandom_range(0, 38)), $urandom_range(1000, 30000));
            run_traffic(PHASE_EDGES, PHASE_FRAMES);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_SYNC_LOW_MIN;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_ready   = 1'b0;
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        tick_now      = '0;
        mismatches    = 0;
        frames_seen   = 0;
        edges_sent    = 0;
        cycle_count   = 0;
        clear_line_state();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_reset_windows();
        test_low_extremes();
        test_high_extremes();
        test_random_windows();
        write_windows(SYNC_LOW_MIN_RST, SYNC_LOW_MAX_RST, ONE_HIGH_MIN_RST, ONE_HIGH_MAX_RST,
                      ZERO_LOW_MIN_RST, ZERO_LOW_MAX_RST, GLITCH_LIMIT_RST,
                      $urandom_range(0, 8000));
        run_traffic(PHASE_EDGES, PHASE_FRAMES);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== rf_remote_pulse_width_decoder_top.f =====
design/rfpwd_pkg.sv
design/rf_remote_pulse_width_decoder_top.sv
design/rfpwd_checker.sv
test/rf_remote_pulse_width_decoder_top_tb.sv
